// ----- hdl/tbs_pkg.sv -----
// Package for the texture bilinear sampler: store geometry, fixed-point widths,
// channel payload types and the structs passed between the sampler's modules.
// Depends on nothing; every other file of the sampler uses it.
package tbs_pkg;

  // Texel store geometry.
  localparam int MaxWidth  = 256;
  localparam int MaxHeight = 256;
  localparam int AddrW     = $clog2(MaxWidth * MaxHeight);

  // Coordinate and dimension formats.
  localparam int CoordW   = 17;                 // unsigned Q1.16
  localparam int CoordOne = 1 << (CoordW - 1);  // 1.0
  localparam int DimW     = 9;                  // width of the dimension registers
  localparam int PosW     = CoordW + DimW;      // scaled position, 16 fractional bits
  localparam int PosFrac  = CoordW - 1;
  localparam int FracW    = 8;                  // weight fraction bits
  localparam int WeightOne = 1 << FracW;
  localparam int WeightW  = 2 * FracW + 1;      // product of two weights, up to 1.0
  localparam int ChanW    = 8;
  localparam int TexelW   = 3 * ChanW;
  localparam int AccW     = ChanW + 2 * FracW;  // channel times weight, sums stay below 2^24

  typedef enum logic {
    OpWrite  = 1'b0,
    OpSample = 1'b1
  } tbs_op_e;

  typedef enum logic {
    FilterPoint    = 1'b0,
    FilterBilinear = 1'b1
  } tbs_filter_e;

  typedef enum logic [1:0] {
    CfgFilterMode = 2'd0,
    CfgTexWidth   = 2'd1,
    CfgTexHeight  = 2'd2
  } tbs_cfg_e;

  // Input transaction payload.
  typedef struct packed {
    logic              operation;
    logic [7:0]        texel_x;
    logic [7:0]        texel_y;
    logic [ChanW-1:0]  red_in;
    logic [ChanW-1:0]  green_in;
    logic [ChanW-1:0]  blue_in;
    logic [CoordW-1:0] u_coord;
    logic [CoordW-1:0] v_coord;
  } tbs_in_t;

  // Output transaction payload.
  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
  } tbs_out_t;

  // Configuration as seen by the coordinate pipeline.
  typedef struct packed {
    tbs_filter_e     mode;
    logic [DimW-1:0] w_m1;
    logic [DimW-1:0] h_m1;
  } tbs_cfg_t;

  // One decoded item waiting for the memory port.
  typedef struct packed {
    tbs_op_e           op;
    logic              wr_ok;
    logic [AddrW-1:0]  addr;
    logic [TexelW-1:0] wdata;
    logic              bil;
    logic [FracW-1:0]  fu;
    logic [FracW-1:0]  fv;
  } tbs_item_t;

  // Tag travelling alongside the registered read data.
  typedef struct packed {
    logic               valid;
    logic               first;
    logic               last;
    logic [WeightW-1:0] weight;
  } tbs_rtag_t;

  // Output buffer status towards the sequencer.
  typedef struct packed {
    logic credit_ok;
    logic full;
  } tbs_blend_st_t;

  // Dimension register clamped to 1..maxv, returned minus one.
  function automatic logic [DimW-1:0] clamp_dim_m1(logic [DimW-1:0] d, int maxv);
    logic [DimW-1:0] r;
    if (d == '0) begin
      r = '0;
    end else if (32'(d) > maxv) begin
      r = DimW'(maxv - 1);
    end else begin
      r = d - DimW'(1);
    end
    return r;
  endfunction

endpackage

// ----- hdl/tbs_if.sv -----
// Valid/ready channel interfaces for the sampler's input and output transactions.
// Depends on tbs_pkg for the payload types.
interface tbs_in_if;
  logic             valid;
  logic             ready;
  tbs_pkg::tbs_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tbs_out_if;
  logic              valid;
  logic              ready;
  tbs_pkg::tbs_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/tbs_front.sv -----
// Coordinate pipeline: saturates and scales u and v, then splits the scaled
// position into texel address, filter weights fraction and edge decision.
// Depends on tbs_pkg and the tbs_in_if interface.
module tbs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tbs_pkg::tbs_cfg_t   cfg_i,
  tbs_in_if.sink              in_i,
  output logic                item_valid_o,
  output tbs_pkg::tbs_item_t  item_o,
  input  logic                item_ready_i
);
  import tbs_pkg::*;

  // Stage one: scaled coordinates and write fields.
  logic              s1_v_q, s1_v_d;
  tbs_op_e           s1_op_q;
  logic              s1_wr_ok_q;
  logic [AddrW-1:0]  s1_waddr_q;
  logic [TexelW-1:0] s1_wdata_q;
  logic [PosW-1:0]   s1_pu_q, s1_pv_q;

  // Stage two: the decoded item.
  logic              s2_v_q, s2_v_d;
  tbs_item_t         s2_q, s2_d;

  logic              s2_free, s1_free, in_fire, s1_move;
  logic [CoordW-1:0] u_sat, v_sat;
  logic [PosW-1:0]   pu_d, pv_d, pu_rnd, pv_rnd;
  logic [DimW-1:0]   x_sel, y_sel;

  // Handshake through the two stages.
  always_comb begin
    s2_free = !s2_v_q || item_ready_i;
    s1_move = s1_v_q && s2_free;
    s1_free = !s1_v_q || s2_free;
    in_fire = in_i.valid && s1_free;
    s1_v_d  = in_fire || (s1_v_q && !s2_free);
    s2_v_d  = s1_move || (s2_v_q && !item_ready_i);
  end

  assign in_i.ready   = s1_free;
  assign item_valid_o = s2_v_q;
  assign item_o       = s2_q;

  // Saturate to 1.0 and scale by the dimension minus one.
  always_comb begin
    u_sat = (in_i.payload.u_coord > CoordW'(CoordOne)) ? CoordW'(CoordOne)
                                                        : in_i.payload.u_coord;
    v_sat = (in_i.payload.v_coord > CoordW'(CoordOne)) ? CoordW'(CoordOne)
                                                        : in_i.payload.v_coord;
    pu_d  = PosW'(u_sat) * PosW'(cfg_i.w_m1);
    pv_d  = PosW'(v_sat) * PosW'(cfg_i.h_m1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q    <= tbs_op_e'(in_i.payload.operation);
      s1_wr_ok_q <= (32'(in_i.payload.texel_x) < MaxWidth) &&
                    (32'(in_i.payload.texel_y) < MaxHeight);
      s1_waddr_q <= AddrW'(in_i.payload.texel_y) * AddrW'(MaxWidth) +
                    AddrW'(in_i.payload.texel_x);
      s1_wdata_q <= {in_i.payload.red_in, in_i.payload.green_in, in_i.payload.blue_in};
      s1_pu_q    <= pu_d;
      s1_pv_q    <= pv_d;
    end
    if (s1_move) begin
      s2_q <= s2_d;
    end
  end

  // Point mode rounds to the nearest texel; bilinear mode truncates and keeps
  // the top fraction bits. A base texel on the last column or row is not blended.
  always_comb begin
    pu_rnd = s1_pu_q + PosW'(1 << (PosFrac - 1));
    pv_rnd = s1_pv_q + PosW'(1 << (PosFrac - 1));
    s2_d       = '0;
    s2_d.op    = s1_op_q;
    s2_d.wr_ok = s1_wr_ok_q;
    s2_d.wdata = s1_wdata_q;
    if (cfg_i.mode == FilterBilinear) begin
      x_sel = s1_pu_q[PosFrac +: DimW];
      y_sel = s1_pv_q[PosFrac +: DimW];
    end else begin
      x_sel = pu_rnd[PosFrac +: DimW];
      y_sel = pv_rnd[PosFrac +: DimW];
    end
    s2_d.bil = (cfg_i.mode == FilterBilinear) && (x_sel < cfg_i.w_m1) &&
               (y_sel < cfg_i.h_m1);
    if (s2_d.bil) begin
      s2_d.fu = s1_pu_q[PosFrac-1 -: FracW];
      s2_d.fv = s1_pv_q[PosFrac-1 -: FracW];
    end
    if (s1_op_q == OpSample) begin
      s2_d.addr = AddrW'(y_sel) * AddrW'(MaxWidth) + AddrW'(x_sel);
    end else begin
      s2_d.addr = s1_waddr_q;
    end
  end

endmodule

// ----- hdl/tbs_seq.sv -----
// Memory sequencer: owns the single-port texel store and issues one access a
// cycle unless held for credit: a write, a read, or four weighted neighbour reads.
// Depends on tbs_pkg.
module tbs_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  input  tbs_pkg::tbs_item_t          item_i,
  output logic                        item_ready_o,
  input  logic                        credit_ok_i,
  output logic                        credit_take_o,
  output tbs_pkg::tbs_rtag_t          rtag_o,
  output logic [tbs_pkg::TexelW-1:0]  rdata_o
);
  import tbs_pkg::*;

  // Texel store, row-major, undefined until written.
  logic [TexelW-1:0] mem [MaxWidth * MaxHeight];
  logic [TexelW-1:0] rdata_q;

  logic [1:0]        k_q, k_d;
  tbs_rtag_t         rtag_q, rtag_d;
  logic              is_sample, last, hold, fire, mem_en, mem_we;
  logic [AddrW-1:0]  addr, offset;
  logic [FracW:0]    hw, vw;

  // Step through the neighbours. Only the final read of a sample needs a free
  // output slot; all accesses use the one port in order, so no hazards arise.
  always_comb begin
    is_sample     = (item_i.op == OpSample);
    last          = !is_sample || !item_i.bil || (k_q == 2'd3);
    hold          = is_sample && last && !credit_ok_i;
    fire          = item_valid_i && !hold;
    item_ready_o  = fire && last;
    credit_take_o = fire && is_sample && last;
    mem_en        = fire && (is_sample || item_i.wr_ok);
    mem_we        = !is_sample;
    k_d           = k_q;
    if (fire) begin
      k_d = last ? 2'd0 : k_q + 2'd1;
    end
  end

  // Neighbour address and weight of the current read.
  always_comb begin
    offset = (k_q[1] ? AddrW'(MaxWidth) : AddrW'(0)) + (k_q[0] ? AddrW'(1) : AddrW'(0));
    addr   = is_sample ? item_i.addr + offset : item_i.addr;
    hw     = k_q[0] ? {1'b0, item_i.fu} : (FracW+1)'(WeightOne) - {1'b0, item_i.fu};
    vw     = k_q[1] ? {1'b0, item_i.fv} : (FracW+1)'(WeightOne) - {1'b0, item_i.fv};
    rtag_d        = '0;
    rtag_d.valid  = fire && is_sample;
    rtag_d.first  = (k_q == 2'd0);
    rtag_d.last   = last;
    rtag_d.weight = WeightW'(hw) * WeightW'(vw);
  end

  always_ff @(posedge clk_i) begin
    if (mem_en) begin
      if (mem_we) begin
        mem[addr] <= item_i.wdata;
      end else begin
        rdata_q <= mem[addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= 2'd0;
      rtag_q <= '0;
    end else begin
      k_q    <= k_d;
      rtag_q <= rtag_d;
    end
  end

  assign rtag_o  = rtag_q;
  assign rdata_o = rdata_q;

endmodule

// ----- hdl/tbs_blend.sv -----
// Blend unit: accumulates weighted texels as read data returns, rounds each
// channel, and holds results in a two-entry output buffer with credit count.
// Depends on tbs_pkg and the tbs_out_if interface.
module tbs_blend (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tbs_pkg::tbs_rtag_t          rtag_i,
  input  logic [tbs_pkg::TexelW-1:0]  rdata_i,
  input  logic                        credit_take_i,
  output tbs_pkg::tbs_blend_st_t      st_o,
  tbs_out_if.source                   out_o
);
  import tbs_pkg::*;

  logic [AccW-1:0] acc_q [3];
  logic [AccW-1:0] sum [3];
  logic [AccW-1:0] rnd [3];
  tbs_out_t        fifo_q [2];
  tbs_out_t        res;
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      fcnt_q, fcnt_d, cred_q, cred_d;
  logic            push, pop;

  // Weighted sum per channel; the weights total 1.0, so the rounded value
  // never exceeds the largest channel value.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = (rtag_i.first ? AccW'(0) : acc_q[c]) +
               AccW'(rdata_i[c*ChanW +: ChanW]) * AccW'(rtag_i.weight);
      rnd[c] = sum[c] + AccW'(1 << (2 * FracW - 1));
    end
    res.red_out   = rnd[2][2*FracW +: ChanW];
    res.green_out = rnd[1][2*FracW +: ChanW];
    res.blue_out  = rnd[0][2*FracW +: ChanW];
  end

  always_ff @(posedge clk_i) begin
    if (rtag_i.valid) begin
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= sum[c];
      end
    end
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  // Buffer occupancy and credits; a credit covers a result still in flight.
  always_comb begin
    push   = rtag_i.valid && rtag_i.last;
    pop    = out_o.valid && out_o.ready;
    fcnt_d = fcnt_q + 2'(push) - 2'(pop);
    cred_d = cred_q + 2'(credit_take_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fcnt_q   <= 2'd0;
      cred_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      fcnt_q <= fcnt_d;
      cred_q <= cred_d;
    end
  end

  assign out_o.valid   = (fcnt_q != 2'd0);
  assign out_o.payload = fifo_q[rd_ptr_q];
  assign st_o.credit_ok = (cred_q < 2'd2);
  assign st_o.full      = (fcnt_q == 2'd2);

endmodule

// ----- hdl/texture_bilinear_sampler.sv -----
// Texture sampler with point and bilinear filtering over a 256 by 256 RGB store.
// Input transactions arrive on in_i: a write stores one texel, a sample returns
// one colour on out_o; writes return nothing. Both channels use valid/ready.
// Configuration (filter mode, width, height) is written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user must write it only while no transaction
// is in progress, as the block itself does not enforce this. A sample's result
// passes the coordinate stages, the store read register and the output buffer.
// Throughput: one write per cycle unless a held sample is ahead of it; samples
// that read a single texel are limited by the two output credits, because a
// credit can be taken again only in the cycle after its result has left; a
// bilinear sample makes four texel fetches, each taking the single store port.
// Reset sets point mode and a 256 by 256 texture and empties the pipeline; the
// store is not cleared, and a texel must be written before it is sampled.
// When the receiver stalls, up to two results wait in the output buffer while
// the pipeline keeps working; after that the sequencer holds its last read and
// back-pressure reaches in_i.ready.
// Depends on tbs_pkg, tbs_if, tbs_front, tbs_seq and tbs_blend.
module texture_bilinear_sampler (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  tbs_in_if.sink                     in_i,
  tbs_out_if.source                  out_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [tbs_pkg::DimW-1:0]   cfg_data_i
);
  import tbs_pkg::*;

  tbs_filter_e     mode_q;
  logic [DimW-1:0] width_q, height_q;
  tbs_cfg_t        cfg;
  logic            item_valid, item_ready, credit_take;
  tbs_item_t       item;
  tbs_rtag_t       rtag;
  logic [TexelW-1:0] rdata;
  tbs_blend_st_t   blend_st;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= FilterPoint;
      width_q  <= DimW'(256);
      height_q <= DimW'(256);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgFilterMode: mode_q   <= tbs_filter_e'(cfg_data_i[0]);
        CfgTexWidth:   width_q  <= cfg_data_i;
        CfgTexHeight:  height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.mode = mode_q;
    cfg.w_m1 = clamp_dim_m1(width_q, MaxWidth);
    cfg.h_m1 = clamp_dim_m1(height_q, MaxHeight);
  end

  tbs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_i         (in_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  tbs_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_ready_o  (item_ready),
    .credit_ok_i   (blend_st.credit_ok),
    .credit_take_o (credit_take),
    .rtag_o        (rtag),
    .rdata_o       (rdata)
  );

  tbs_blend u_blend (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rtag_i        (rtag),
    .rdata_i       (rdata),
    .credit_take_i (credit_take),
    .st_o          (blend_st),
    .out_o         (out_o)
  );

`ifndef SYNTHESIS
  // A sample's final read is only issued with a free output slot.
  a_take_has_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_take |-> blend_st.credit_ok)
    else $error("final read issued without an output credit");

  // A finished result never lands in a full output buffer.
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rtag.valid && rtag.last) |-> !blend_st.full)
    else $error("result pushed into a full output buffer");

  // Every returned final read was issued by a sample in the previous cycle.
  a_read_follows_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rtag.valid && rtag.last |-> $past(item_valid && item.op == OpSample))
    else $error("read data returned without a sample issue");
`endif

endmodule
